// ===== rtl/mhs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared constants and types of the max-heap sort unit.
// ----------------------------------------------------------------------------
package mhs_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // store address, element count and child index widths
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int KID_W  = ADDR_W + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef enum logic [15:0] {
      S_IDLE   = 16'b0000_0000_0000_0001,
      S_BUILD  = 16'b0000_0000_0000_0010,
      S_EXTR   = 16'b0000_0000_0000_0100,
      S_SW_A   = 16'b0000_0000_0000_1000,
      S_SW_B   = 16'b0000_0000_0001_0000,
      S_SW_C   = 16'b0000_0000_0010_0000,
      S_LOAD   = 16'b0000_0000_0100_0000,
      S_HOLD   = 16'b0000_0000_1000_0000,
      S_RD_L   = 16'b0000_0001_0000_0000,
      S_RD_R   = 16'b0000_0010_0000_0000,
      S_PICK   = 16'b0000_0100_0000_0000,
      S_TEST   = 16'b0000_1000_0000_0000,
      S_PUT    = 16'b0001_0000_0000_0000,
      S_E_RD   = 16'b0010_0000_0000_0000,
      S_E_LD   = 16'b0100_0000_0000_0000,
      S_E_WAIT = 16'b1000_0000_0000_0000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/mhs_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhs channels
// Valid/ready channels carrying input items and sorted result items.
// ----------------------------------------------------------------------------
interface mhs_req_if import mhs_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type value;
   logic     final_item;

   modport source (output valid, output value, output final_item, input ready);
   modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface mhs_rsp_if import mhs_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     end_of_set;
   logic     overflowed;

   modport source (output valid, output sorted_value, output end_of_set,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input end_of_set,
                   input overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/max_heap_sort_unit.sv =====
`default_nettype none
// A non-final item is stored and the unit stays idle; a final item then runs a
// heap build and extraction. A build sift-down opens with BUILD, LOAD and HOLD,
// an extraction one with EXTR and the root swap SW_A, SW_B and SW_C; each heap
// level takes RD_L, RD_R, PICK and TEST, then PUT writes back, as the element store
// has one registered read port. Each result waits in E_WAIT for a ready sink.
// No item is taken until the whole set is delivered. Sync reset empties the set.
// ----------------------------------------------------------------------------
// max_heap_sort_unit
// Collects a set of signed values, heap-sorts it in place and emits it in
// ascending order.
// ----------------------------------------------------------------------------
module max_heap_sort_unit import mhs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mhs_req_if.sink   req_bus,
   mhs_rsp_if.source rsp_bus
);

   data_type heap_mem [CAPACITY];

   state_type             state_ff,      state_in;
   logic [CNT_W-1:0]      count_ff,      count_in;
   logic                  drop_ff,       drop_in;
   logic [CNT_W-1:0]      n_ff,          n_in;
   logic [CNT_W-1:0]      heap_len_ff,   heap_len_in;
   logic [CNT_W-1:0]      i_ff,          i_in;
   logic                  build_ff,      build_in;
   logic [ADDR_W-1:0]     node_ff,       node_in;
   logic [KID_W-1:0]      kid_ff,        kid_in;
   data_type              held_ff,       held_in;
   data_type              left_ff,       left_in;
   data_type              child_ff,      child_in;
   logic [ADDR_W-1:0]     child_idx_ff,  child_idx_in;
   logic [ADDR_W-1:0]     k_ff,          k_in;
   data_type              out_value_ff,  out_value_in;
   logic                  out_last_ff,   out_last_in;
   logic                  out_ovf_ff,    out_ovf_in;
   data_type              rd_data_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   data_type          wr_data;

   data_type cmp_a, cmp_b;
   logic     cmp_lt;

   logic             req_take;
   logic             has_right;
   logic [KID_W-1:0] len_ext;
   logic [KID_W-1:0] next_kid;
   logic [CNT_W-1:0] count_inc;

   mhs_cmp u_cmp (
      .op_a   (cmp_a),
      .op_b   (cmp_b),
      .a_lt_b (cmp_lt)
   );

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = (state_ff == S_E_WAIT);
   assign rsp_bus.sorted_value = out_value_ff;
   assign rsp_bus.end_of_set   = out_last_ff;
   assign rsp_bus.overflowed   = out_ovf_ff;

   assign req_take  = req_bus.valid && (state_ff == S_IDLE);
   assign len_ext   = KID_W'(heap_len_ff);
   assign has_right = (kid_ff + KID_W'(1)) < len_ext;
   assign next_kid  = {child_idx_ff, 1'b1};
   assign count_inc = count_ff + CNT_W'(1);

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      n_in         = n_ff;
      heap_len_in  = heap_len_ff;
      i_in         = i_ff;
      build_in     = build_ff;
      node_in      = node_ff;
      kid_in       = kid_ff;
      held_in      = held_ff;
      left_in      = left_ff;
      child_in     = child_ff;
      child_idx_in = child_idx_ff;
      k_in         = k_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = held_ff;
      cmp_a        = left_ff;
      cmp_b        = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (count_ff < CNT_W'(CAPACITY)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = req_bus.value;
                  count_in = count_inc;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_bus.final_item) begin
                  n_in        = (count_ff < CNT_W'(CAPACITY)) ? count_inc : count_ff;
                  heap_len_in = n_in;
                  i_in        = n_in >> 1;
                  build_in    = 1'b1;
                  state_in    = S_BUILD;
               end
            end
         end
         S_BUILD: begin
            if (i_ff != '0) begin
               node_in  = ADDR_W'(i_ff - CNT_W'(1));
               state_in = S_LOAD;
            end else begin
               build_in = 1'b0;
               i_in     = n_ff;
               state_in = S_EXTR;
            end
         end
         S_EXTR: begin
            if (i_ff > CNT_W'(1)) begin
               state_in = S_SW_A;
            end else begin
               k_in     = '0;
               state_in = S_E_RD;
            end
         end
         S_SW_A: begin
            rd_addr  = '0;
            state_in = S_SW_B;
         end
         S_SW_B: begin
            rd_addr  = ADDR_W'(i_ff - CNT_W'(1));
            child_in = rd_data_ff;          // old root
            state_in = S_SW_C;
         end
         S_SW_C: begin
            // old root goes to the tail, tail value sifts down from the root
            wr_en       = 1'b1;
            wr_addr     = ADDR_W'(i_ff - CNT_W'(1));
            wr_data     = child_ff;
            held_in     = rd_data_ff;
            heap_len_in = i_ff - CNT_W'(1);
            node_in     = '0;
            kid_in      = KID_W'(1);
            state_in    = (KID_W'(1) < KID_W'(heap_len_in)) ? S_RD_L : S_PUT;
         end
         S_LOAD: begin
            rd_addr  = node_ff;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            held_in  = rd_data_ff;
            kid_in   = {node_ff, 1'b1};
            state_in = ({node_ff, 1'b1} < len_ext) ? S_RD_L : S_PUT;
         end
         S_RD_L: begin
            rd_addr  = kid_ff[ADDR_W-1:0];
            state_in = S_RD_R;
         end
         S_RD_R: begin
            rd_addr  = ADDR_W'(kid_ff + KID_W'(1));
            left_in  = rd_data_ff;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmp_a = left_ff;
            cmp_b = rd_data_ff;
            if (has_right && cmp_lt) begin
               child_in     = rd_data_ff;
               child_idx_in = ADDR_W'(kid_ff + KID_W'(1));
            end else begin
               child_in     = left_ff;
               child_idx_in = kid_ff[ADDR_W-1:0];
            end
            state_in = S_TEST;
         end
         S_TEST: begin
            cmp_a = held_ff;
            cmp_b = child_ff;
            if (cmp_lt) begin
               wr_en    = 1'b1;
               wr_addr  = node_ff;
               wr_data  = child_ff;
               node_in  = child_idx_ff;
               kid_in   = next_kid;
               state_in = (next_kid < len_ext) ? S_RD_L : S_PUT;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff;
            wr_data  = held_ff;
            i_in     = i_ff - CNT_W'(1);
            state_in = build_ff ? S_BUILD : S_EXTR;
         end
         S_E_RD: begin
            rd_addr  = k_ff;
            state_in = S_E_LD;
         end
         S_E_LD: begin
            out_value_in = rd_data_ff;
            out_last_in  = (CNT_W'(k_ff) + CNT_W'(1)) == n_ff;
            out_ovf_in   = drop_ff;
            state_in     = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (rsp_bus.ready) begin
               if (out_last_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + ADDR_W'(1);
                  state_in = S_E_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      heap_len_ff  <= heap_len_in;
      i_ff         <= i_in;
      build_ff     <= build_in;
      node_ff      <= node_in;
      kid_ff       <= kid_in;
      held_ff      <= held_in;
      left_ff      <= left_in;
      child_ff     <= child_in;
      child_idx_ff <= child_idx_in;
      k_ff         <= k_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

endmodule
`default_nettype wire

// ===== rtl/mhs_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhs_cmp
// Shared signed (two's complement) comparator used by the PICK and TEST steps of every sift-down.
// ----------------------------------------------------------------------------
module mhs_cmp import mhs_pkg::*; (
   input  data_type op_a,
   input  data_type op_b,
   output logic     a_lt_b
);

   assign a_lt_b = (op_a < op_b);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_heap_sort_unit. Sets of signed values are
// streamed in with bursty gaps, and every sorted item coming back is compared
// with a behavioral sort of the same set. The result side stalls in changing
// patterns. Sets beyond the store depth check the overflow flag.
// ----------------------------------------------------------------------------
module tb_top;
   import mhs_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 250;

   typedef struct {
      data_type value;
      logic     final_item;
   } set_value_type;

   typedef struct {
      data_type value;
      logic     end_of_set;
      logic     overflowed;
   } sorted_value_type;

   logic clock;
   logic reset;

   mhs_req_if req_if ();
   mhs_rsp_if rsp_if ();

   max_heap_sort_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   set_value_type    pending_values[$];
   sorted_value_type expected_sorted[$];

   // behavioral copy of the open set
   data_type    set_store[CAPACITY];
   int unsigned set_count;
   bit          set_dropped;

   int error_count;
   int quiet_cycles;
   int burst_left;
   int gap_left;
   int ready_mode;
   int ready_tick;
   set_value_type next_item;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.value      = '0;
      req_if.final_item = 1'b0;
      rsp_if.ready      = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // store one value; a final item sorts the set into the expected stream
   function automatic void absorb_value(input data_type v, input logic fin);
      data_type         held;
      int               j;
      sorted_value_type res;
      if (set_count < CAPACITY) begin
         set_store[set_count] = v;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (fin) begin
         for (int i = 1; i < set_count; i++) begin
            held = set_store[i];
            j = i;
            while (j > 0 && set_store[j-1] > held) begin
               set_store[j] = set_store[j-1];
               j--;
            end
            set_store[j] = held;
         end
         for (int k = 0; k < set_count; k++) begin
            res.value      = set_store[k];
            res.end_of_set = (k == set_count - 1);
            res.overflowed = set_dropped;
            expected_sorted.push_back(res);
         end
         set_count   = 0;
         set_dropped = 1'b0;
      end
   endfunction

   function automatic data_type pick_value();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6)
         return data_type'($urandom);
      else if (kind < 8)
         return data_type'(int'($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 4))
         0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return data_type'(1);
      endcase
   endfunction

   function automatic void queue_value(input data_type v, input logic fin);
      set_value_type it;
      it.value      = v;
      it.final_item = fin;
      pending_values.push_back(it);
   endfunction

   function automatic void queue_random_set(input int size);
      for (int i = 0; i < size; i++)
         queue_value(pick_value(), i == size - 1);
   endfunction

   // sender: bursts of items with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0 || pending_values.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            next_item = pending_values.pop_front();
            req_if.valid      <= 1'b1;
            req_if.value      <= next_item.value;
            req_if.final_item <= next_item.final_item;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15)
                                                      : $urandom_range(0, 3);
            end
         end
      end
   end

   // prediction on input handshakes, checking and stalls on the result side
   always @(posedge clock) begin
      sorted_value_type exp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_mode = 0;
         ready_tick = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            absorb_value(req_if.value, req_if.final_item);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_sorted.size() == 0) begin
               flag_mismatch($sformatf("unexpected item value=%0d",
                                       rsp_if.sorted_value));
            end else begin
               exp = expected_sorted.pop_front();
               if (rsp_if.sorted_value !== exp.value)
                  flag_mismatch($sformatf("sorted_value %0d, want %0d",
                                          rsp_if.sorted_value, exp.value));
               if (rsp_if.end_of_set !== exp.end_of_set)
                  flag_mismatch($sformatf("end_of_set %b, want %b",
                                          rsp_if.end_of_set, exp.end_of_set));
               if (rsp_if.overflowed !== exp.overflowed)
                  flag_mismatch($sformatf("overflowed %b, want %b",
                                          rsp_if.overflowed, exp.overflowed));
            end
         end
         ready_tick++;
         if (ready_tick % 256 == 0)
            ready_mode = $urandom_range(0, 3);
         case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ready_tick[2];
            default: rsp_if.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int random_count;
      int big_sets;
      int size;
      int r;
      reset        = 1'b1;
      error_count  = 0;
      quiet_cycles = 0;
      set_count    = 0;
      set_dropped  = 1'b0;
      foreach (set_store[i])
         set_store[i] = '0;

      // directed: single-item sets at both extremes
      queue_value({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b1);
      queue_value({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
      // extremes mixed with duplicates
      queue_value({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
      queue_value({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b0);
      queue_value('0, 1'b0);
      queue_value('1, 1'b0);
      queue_value(data_type'(1), 1'b0);
      queue_value({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b0);
      queue_value({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
      queue_value({1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1}, 1'b0);
      queue_value({1'b0, {(DATA_WIDTH-2){1'b1}}, 1'b0}, 1'b0);
      queue_value(data_type'(5), 1'b0);
      queue_value(data_type'(5), 1'b1);
      // descending, ascending, equal pair
      queue_value(data_type'(3), 1'b0);
      queue_value(data_type'(2), 1'b0);
      queue_value(data_type'(1), 1'b1);
      for (int i = 1; i <= 4; i++)
         queue_value(data_type'(i), i == 4);
      queue_value('0, 1'b0);
      queue_value('0, 1'b1);

      // a full store, then one that drops its tail including the final item
      queue_random_set(CAPACITY);
      queue_random_set(CAPACITY + 3);
      random_count = 2 * CAPACITY + 3;
      big_sets = 2;
      while (random_count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r == 0 && big_sets < 4) begin
            size = $urandom_range(CAPACITY, CAPACITY + 4);
            big_sets++;
         end else if (r < 4) begin
            size = $urandom_range(11, 40);
         end else begin
            size = $urandom_range(1, 10);
         end
         queue_random_set(size);
         random_count += size;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_if.valid || expected_sorted.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_sorted.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
